>>> sv/binomial_coefficient_unit_assert.svh
// Assertion macros shared by the binomial coefficient checker.
`ifndef BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define BCU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("binomial coefficient unit assertion failed");

// Next-cycle implication, off while reset is low.
`define BCU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("binomial coefficient unit assertion failed");

// Next-cycle implication that also holds through reset.
`define BCU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("binomial coefficient unit assertion failed");

`endif

>>> sv/bcu_pkg.sv
// Package for the binomial coefficient unit: control word types and microcode ROM.
`timescale 1ns / 1ps
package bcu_pkg;

    localparam int STEP_BITS = 3;
    typedef logic [STEP_BITS-1:0] t_step;

    // Program step addresses
    localparam t_step STEP_LOAD = 3'd0;
    localparam t_step STEP_PREP = 3'd1;
    localparam t_step STEP_LOOP = 3'd2;
    localparam t_step STEP_MUL  = 3'd3;
    localparam t_step STEP_CHK  = 3'd4;
    localparam t_step STEP_DIV  = 3'd5;
    localparam t_step STEP_NEXT = 3'd6;
    localparam t_step STEP_DONE = 3'd7;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,  // latch a new item
        OP_PREP  = 3'd1,  // pick n and k, handle the trivial cases
        OP_MINIT = 3'd2,  // start the multiply by (n - i)
        OP_MSTEP = 3'd3,  // one shift-add multiply bit
        OP_DINIT = 3'd4,  // overflow check, start the divide by (i + 1)
        OP_DSTEP = 3'd5,  // one restoring divide bit
        OP_NEXT  = 3'd6,  // take the quotient, advance i
        OP_EMIT  = 3'd7   // move the result into the output register
    } t_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NOFIRE  = 3'd0,
        C_SPECIAL = 3'd1,
        C_IEQK    = 3'd2,
        C_NOTLAST = 3'd3,
        C_OVF     = 3'd4,
        C_ALWAYS  = 3'd5,
        C_OUTBUSY = 3'd6
    } t_cond;

    typedef struct packed {
        logic  accept;
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Status flags the datapath reports back to the sequencer
    typedef struct packed {
        logic special;
        logic i_eq_k;
        logic cnt_last;
        logic ovf;
        logic out_busy;
    } t_status;

    // Microcode: jump to target when cond holds, otherwise fall through to step + 1
    // (the last step wraps back to the load step).
    function automatic t_ctrl ctrl_rom(input t_step step);
        t_ctrl w;
        unique case (step)
            STEP_LOAD: w = '{accept: 1'b1, op: OP_LOAD,  cond: C_NOFIRE,  target: STEP_LOAD};
            STEP_PREP: w = '{accept: 1'b0, op: OP_PREP,  cond: C_SPECIAL, target: STEP_DONE};
            STEP_LOOP: w = '{accept: 1'b0, op: OP_MINIT, cond: C_IEQK,    target: STEP_DONE};
            STEP_MUL:  w = '{accept: 1'b0, op: OP_MSTEP, cond: C_NOTLAST, target: STEP_MUL};
            STEP_CHK:  w = '{accept: 1'b0, op: OP_DINIT, cond: C_OVF,     target: STEP_DONE};
            STEP_DIV:  w = '{accept: 1'b0, op: OP_DSTEP, cond: C_NOTLAST, target: STEP_DIV};
            STEP_NEXT: w = '{accept: 1'b0, op: OP_NEXT,  cond: C_ALWAYS,  target: STEP_LOOP};
            STEP_DONE: w = '{accept: 1'b0, op: OP_EMIT,  cond: C_OUTBUSY, target: STEP_DONE};
            default:   w = '{accept: 1'b1, op: OP_LOAD,  cond: C_NOFIRE,  target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

>>> sv/bcu_in_if.sv
// Input channel of the binomial coefficient unit: command and two counts.
`timescale 1ns / 1ps
interface bcu_in_if #(
    parameter int COUNT_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COUNT_BITS-1:0] first_count;
    logic [COUNT_BITS-1:0] second_count;

    modport source (output valid, output cmd, output first_count, output second_count,
                    input ready);
    modport sink   (input valid, input cmd, input first_count, input second_count,
                    output ready);
endinterface

>>> sv/bcu_out_if.sv
// Output channel of the binomial coefficient unit: coefficient and overflow flag.
`timescale 1ns / 1ps
interface bcu_out_if #(
    parameter int RESULT_BITS = 64
);
    logic                   valid;
    logic                   ready;
    logic [RESULT_BITS-1:0] coefficient;
    logic                   overflow;

    modport source (output valid, output coefficient, output overflow, input ready);
    modport sink   (input valid, input coefficient, input overflow, output ready);
endinterface

>>> sv/bcu_sequencer.sv
// Microcode sequencer: step counter, control ROM and jump condition select.
`timescale 1ns / 1ps
module bcu_sequencer
    import bcu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_fire,
    output t_op     o_op
);

    t_step r_step;
    t_step n_step;
    t_ctrl w_ctrl;
    logic  w_take;

    // Control word fetch
    assign w_ctrl     = ctrl_rom(r_step);
    assign o_in_ready = w_ctrl.accept;
    assign o_fire     = w_ctrl.accept & i_in_valid;
    assign o_op       = w_ctrl.op;

    // Jump condition select
    always_comb begin
        unique case (w_ctrl.cond)
            C_NOFIRE:  w_take = ~o_fire;
            C_SPECIAL: w_take = i_status.special;
            C_IEQK:    w_take = i_status.i_eq_k;
            C_NOTLAST: w_take = ~i_status.cnt_last;
            C_OVF:     w_take = i_status.ovf;
            C_ALWAYS:  w_take = 1'b1;
            C_OUTBUSY: w_take = i_status.out_busy;
            default:   w_take = 1'b0;
        endcase
    end

    assign n_step = w_take ? w_ctrl.target : r_step + t_step'(1);

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> sv/bcu_datapath.sv
// Datapath: operand registers, shift-add multiplier, restoring divider, output register.
`timescale 1ns / 1ps
module bcu_datapath
    import bcu_pkg::*;
#(
    parameter int COUNT_BITS  = 12,
    parameter int RESULT_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  logic                   i_fire,
    input  logic                   i_cmd,
    input  logic [COUNT_BITS-1:0]  i_first,
    input  logic [COUNT_BITS-1:0]  i_second,
    input  logic                   i_out_ready,
    output t_status                o_status,
    output logic                   o_out_valid,
    output logic [RESULT_BITS-1:0] o_coef,
    output logic                   o_ovf
);

    // n of stars and bars needs one bit more than a count
    localparam int NB    = COUNT_BITS + 1;
    localparam int RB    = RESULT_BITS;
    localparam int PB    = RB + NB;
    localparam int STEPS = (RB > NB) ? RB : NB;
    localparam int CW    = $clog2(STEPS + 1);
    localparam logic [NB-1:0] ONE_N = NB'(1);

    logic          r_cmd;
    logic [NB-1:0] r_n;
    logic [NB-1:0] r_k;
    logic [NB-1:0] r_i;
    logic [NB-1:0] r_mplr;
    logic [NB-1:0] r_div;
    logic [NB-1:0] r_rem;
    logic [RB-1:0] r_acc;
    logic [PB-1:0] r_prod;
    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic          r_out_valid;
    logic [RB-1:0] r_coef;
    logic          r_oflag;

    logic [NB-1:0] w_n_eff;
    logic [NB-1:0] w_k_eff;
    logic [NB-1:0] w_n_minus_k;
    logic [NB-1:0] w_k_min;
    logic          w_k_gt_n;
    logic          w_no_bins;
    logic          w_special;
    logic [RB-1:0] w_special_val;
    logic [PB-1:0] w_mul_sum;
    logic [NB:0]   w_trial;
    logic [NB:0]   w_trial_sub;
    logic          w_ge;
    logic          w_prod_ovf;
    logic          w_out_busy;

    // Operand selection for the two commands and the trivial cases
    assign w_n_eff       = r_cmd ? (r_n + r_k - ONE_N) : r_n;
    assign w_k_eff       = r_cmd ? r_n : r_k;
    assign w_n_minus_k   = w_n_eff - w_k_eff;
    assign w_k_gt_n      = w_k_eff > w_n_eff;
    assign w_k_min       = (w_k_eff > w_n_minus_k) ? w_n_minus_k : w_k_eff;
    assign w_no_bins     = r_cmd & (r_k == '0);
    assign w_special     = w_no_bins | w_k_gt_n;
    assign w_special_val = w_no_bins ? {{(RB-1){1'b0}}, (r_n == '0)} : '0;

    // Shift-add multiply, multiplier MSB first
    assign w_mul_sum = {r_prod[PB-2:0], 1'b0}
                     + (r_mplr[NB-1] ? {{NB{1'b0}}, r_acc} : {PB{1'b0}});

    // Restoring divide step on the low word of the product
    assign w_trial     = {r_rem, r_prod[RB-1]};
    assign w_trial_sub = w_trial - {1'b0, r_div};
    assign w_ge        = w_trial >= {1'b0, r_div};

    assign w_prod_ovf = |r_prod[PB-1:RB];
    assign w_out_busy = r_out_valid & ~i_out_ready;

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                if (i_fire) begin
                    r_cmd <= i_cmd;
                    r_n   <= {1'b0, i_first};
                    r_k   <= {1'b0, i_second};
                end
            end
            OP_PREP: begin
                r_ovf <= 1'b0;
                r_i   <= '0;
                if (w_special) begin
                    r_acc <= w_special_val;
                end else begin
                    r_acc <= {{(RB-1){1'b0}}, 1'b1};
                    r_n   <= w_n_eff;
                    r_k   <= w_k_min;
                end
            end
            OP_MINIT: begin
                r_prod <= '0;
                r_mplr <= r_n - r_i;
                r_cnt  <= CW'(NB);
            end
            OP_MSTEP: begin
                r_prod <= w_mul_sum;
                r_mplr <= {r_mplr[NB-2:0], 1'b0};
                r_cnt  <= r_cnt - CW'(1);
            end
            OP_DINIT: begin
                if (w_prod_ovf) begin
                    r_acc <= '1;
                    r_ovf <= 1'b1;
                end
                r_rem <= '0;
                r_div <= r_i + ONE_N;
                r_cnt <= CW'(RB);
            end
            OP_DSTEP: begin
                r_rem            <= w_ge ? w_trial_sub[NB-1:0] : w_trial[NB-1:0];
                r_prod[RB-1:0]   <= {r_prod[RB-2:0], w_ge};
                r_cnt            <= r_cnt - CW'(1);
            end
            OP_NEXT: begin
                r_acc <= r_prod[RB-1:0];
                r_i   <= r_i + ONE_N;
            end
            default: begin
            end
        endcase
    end

    // Output register, parts the sequencer from the sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_op == OP_EMIT) && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_op == OP_EMIT) && !w_out_busy) begin
            r_coef  <= r_acc;
            r_oflag <= r_ovf;
        end
    end

    assign o_status = '{special:  w_special,
                        i_eq_k:   (r_i == r_k),
                        cnt_last: (r_cnt == CW'(1)),
                        ovf:      w_prod_ovf,
                        out_busy: w_out_busy};

    assign o_out_valid = r_out_valid;
    assign o_coef      = r_coef;
    assign o_ovf       = r_oflag;

endmodule

>>> sv/binomial_coefficient_unit.sv
// An item takes k' = min(k, n-k) terms, or none when k > n or there are no bins.
// A term: setup, shift-add multiply, check, divide, update; an overflowing term ends
// after its check. One item at a time; the result becomes valid in the same cycle that
// the next item can be taken, and a result held by the sink stalls the sequencer.
// Reset (sync, active low) empties the output.
`timescale 1ns / 1ps
module binomial_coefficient_unit
    import bcu_pkg::*;
#(
    parameter int COUNT_BITS  = 12,
    parameter int RESULT_BITS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bcu_in_if.sink    i_in,
    bcu_out_if.source o_out
);

    t_status w_status;
    t_op     w_op;
    logic    w_fire;
    logic    w_in_ready;

    // Control sequencer
    bcu_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_fire     (w_fire),
        .o_op       (w_op)
    );

    // Arithmetic datapath
    bcu_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .RESULT_BITS (RESULT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_fire      (w_fire),
        .i_cmd       (i_in.cmd),
        .i_first     (i_in.first_count),
        .i_second    (i_in.second_count),
        .i_out_ready (o_out.ready),
        .o_status    (w_status),
        .o_out_valid (o_out.valid),
        .o_coef      (o_out.coefficient),
        .o_ovf       (o_out.overflow)
    );

    assign i_in.ready = w_in_ready;

endmodule

>>> sv/bcu_checker.sv
// Port-level checker for the binomial coefficient unit, bound to the top level.
`timescale 1ns / 1ps
`include "binomial_coefficient_unit_assert.svh"
module bcu_checker #(
    parameter int RESULT_BITS = 64
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [RESULT_BITS-1:0] i_out_coefficient,
    input logic                   i_out_overflow
);

    // An accepted item keeps the block busy for at least the next cycle
    `BCU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // Overflow always comes with a saturated coefficient
    `BCU_ASSERT_IMP(a_ovf_saturates, i_clk, i_rst_n, i_out_valid && i_out_overflow, i_out_coefficient == {RESULT_BITS{1'b1}})

    // A stalled result holds
    `BCU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_coefficient) && $stable(i_out_overflow))

    // Reset empties the output register
    `BCU_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind binomial_coefficient_unit bcu_checker #(
    .RESULT_BITS (RESULT_BITS)
) u_bcu_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_coefficient (o_out.coefficient),
    .i_out_overflow    (o_out.overflow)
);
